// ===== rtl/lbev_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbev_pkg;

  localparam int GRID_ROWS = 256;
  localparam int GRID_COLS = 256;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int CELL_AW   = $clog2(CELLS);

  localparam int CNT_W   = 6;
  localparam int CELL_DW = CNT_W + 16;

  localparam int DIV_NW = 24;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [2:0] CFG_X_LOW     = 3'd0;
  localparam logic [2:0] CFG_X_HIGH    = 3'd1;
  localparam logic [2:0] CFG_Y_LOW     = 3'd2;
  localparam logic [2:0] CFG_Y_HIGH    = 3'd3;
  localparam logic [2:0] CFG_Z_LOW     = 3'd4;
  localparam logic [2:0] CFG_Z_HIGH    = 3'd5;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd6;

  localparam logic [2:0] STAT_STORED   = 3'd0;
  localparam logic [2:0] STAT_ZERO     = 3'd1;
  localparam logic [2:0] STAT_REGION   = 3'd2;
  localparam logic [2:0] STAT_GRID     = 3'd3;
  localparam logic [2:0] STAT_READOUT  = 3'd4;

  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_CHK, ST_DXH, ST_DYL, ST_DX, ST_DY, ST_DH,
    ST_GRID, ST_RD, ST_MOD, ST_OUT
  } state_e;

  localparam logic [7:0] DENSITY_LUT [64] = '{
    8'd0,   8'd42,  8'd67,  8'd85,  8'd98,  8'd109, 8'd119, 8'd127,
    8'd134, 8'd141, 8'd147, 8'd152, 8'd157, 8'd161, 8'd166, 8'd170,
    8'd173, 8'd177, 8'd180, 8'd183, 8'd186, 8'd189, 8'd192, 8'd194,
    8'd197, 8'd199, 8'd202, 8'd204, 8'd206, 8'd208, 8'd210, 8'd212,
    8'd214, 8'd216, 8'd217, 8'd219, 8'd221, 8'd223, 8'd224, 8'd226,
    8'd227, 8'd229, 8'd230, 8'd232, 8'd233, 8'd234, 8'd236, 8'd237,
    8'd238, 8'd239, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246,
    8'd247, 8'd248, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
  };

endpackage
`default_nettype wire

// ===== rtl/lbev_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbev_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/lbev_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbev_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lbev_pkg::DIV_NW-1:0]    dividend_i,
  input  wire logic [lbev_pkg::DIV_DW-1:0]    divisor_i,
  output logic                                done_o,
  output logic      [lbev_pkg::DIV_NW-1:0]    quot_o,
  output logic      [lbev_pkg::DIV_DW-1:0]    rem_o
);

  logic                          run_q, run_d, done_q, done_d;
  logic [lbev_pkg::DIV_CW-1:0]   cnt_q, cnt_d;
  logic [lbev_pkg::DIV_NW-1:0]   quo_q, quo_d;
  logic [lbev_pkg::DIV_DW-1:0]   rem_q, rem_d, dv_q, dv_d;
  logic [lbev_pkg::DIV_DW:0]     shifted, diff;
  logic                          fits;

  assign shifted = {rem_q, quo_q[lbev_pkg::DIV_NW-1]};
  assign diff    = shifted - {1'b0, dv_q};
  assign fits    = shifted >= {1'b0, dv_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    done_d = 1'b0;
    if (!run_q && start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dv_d  = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[lbev_pkg::DIV_NW-2:0], fits};
      rem_d = fits ? diff[lbev_pkg::DIV_DW-1:0] : shifted[lbev_pkg::DIV_DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lbev_pkg::DIV_CW'(lbev_pkg::DIV_NW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/lidar_bev_grid_builder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+--------------------------------------
// in        | input     | in_valid_i / in_stall_o | func, x/y/z coord, intensity, row/col
// out       | output    | out_valid_o/out_stall_i | status, cell row/col, density,
//           |           |                         | height, intensity
// cfg       | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A point holds in_stall_o high through four or five passes of the shared restoring divider,
// plus a read-modify-write of the cell memory when its cell lies in the grid. A readout or
// a dropped zero or out-of-region point skips the divider. All wait on a stalled output.
// After reset a clearing pass writes every cell once, with in_stall_o high.
// A finished result waits in the output register while the next transfer is taken.
module lidar_bev_grid_builder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [15:0] x_coord_i,
  input  wire logic [15:0] y_coord_i,
  input  wire logic [15:0] z_coord_i,
  input  wire logic [7:0]  point_intensity_i,
  input  wire logic [7:0]  read_row_i,
  input  wire logic [7:0]  read_col_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  status_o,
  output logic      [7:0]  cell_row_o,
  output logic      [7:0]  cell_col_o,
  output logic      [7:0]  density_out_o,
  output logic      [7:0]  height_out_o,
  output logic      [7:0]  intensity_out_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW = lbev_pkg::CELL_AW;
  localparam int DW = lbev_pkg::CELL_DW;

  lbev_pkg::state_e state_q, state_d;

  logic signed [15:0] xl_q, xh_q, yl_q, yh_q, zl_q, zh_q;
  logic        [7:0]  cs_q;

  logic               func_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic        [7:0]  inten_q, rr_q, rc_q;

  logic signed [18:0] fxh_q, fyl_q, tx_q, ty_q;
  logic        [7:0]  h_q;
  logic        [AW-1:0] addr_q;
  logic        [AW-1:0] clr_q;
  logic               issued_q;

  logic [2:0] rs_q;
  logic [7:0] rrow_q, rcol_q, rden_q, rhgt_q, rint_q;
  logic       out_valid_q;

  logic                          div_start, div_done;
  logic [lbev_pkg::DIV_NW-1:0]   div_num, div_quot;
  logic [lbev_pkg::DIV_DW-1:0]   div_den, div_rem;
  logic [7:0]                    cs_eff;
  logic signed [16:0]            div_src;
  logic [16:0]                   div_abs;
  logic signed [18:0]            q_s, trunc_neg, floor_v;
  logic [15:0]                   z_num, z_den;
  logic                          z_open, is_zero, in_roi, read_in_grid, grid_ok, out_load;
  logic signed [18:0]            row_c, col_c;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [5:0]    cnt_old, cnt_new;
  logic [7:0]    hgt_old, int_old, hgt_new, int_new;

  assign cs_eff  = (cs_q == 8'd0) ? 8'd1 : cs_q;
  assign z_open  = zh_q > zl_q;
  assign z_num   = 16'(17'(z_q) - 17'(zl_q));
  assign z_den   = 16'(17'(zh_q) - 17'(zl_q));
  assign is_zero = (x_q == 16'sd0) && (y_q == 16'sd0) && (z_q == 16'sd0);
  assign in_roi  = (x_q >= xl_q) && (x_q <= xh_q) && (y_q >= yl_q) && (y_q <= yh_q) &&
                   (z_q >= zl_q) && (z_q <= zh_q);
  assign read_in_grid = (32'(rr_q) < 32'(lbev_pkg::GRID_ROWS)) &&
                        (32'(rc_q) < 32'(lbev_pkg::GRID_COLS));

  always_comb begin
    case (state_q)
      lbev_pkg::ST_DXH: div_src = 17'(xh_q);
      lbev_pkg::ST_DYL: div_src = 17'(yl_q);
      lbev_pkg::ST_DX:  div_src = 17'(x_q);
      default:          div_src = 17'(y_q);
    endcase
  end

  assign div_abs = div_src[16] ? 17'(-div_src) : 17'(div_src);

  always_comb begin
    if (state_q == lbev_pkg::ST_DH) begin
      div_num = ({8'd0, z_num} << 8) - {8'd0, z_num};
      div_den = z_den;
    end else begin
      div_num = lbev_pkg::DIV_NW'(div_abs);
      div_den = {8'd0, cs_eff};
    end
  end

  assign q_s       = signed'({2'b00, div_quot[16:0]});
  assign trunc_neg = div_src[16] ? q_s : -q_s;
  assign floor_v   = div_src[16] ? -(q_s + 19'(div_rem != '0)) : q_s;

  assign row_c   = tx_q + fxh_q;
  assign col_c   = ty_q - fyl_q;
  assign grid_ok = (row_c >= 19'sd0) && (row_c < 19'(lbev_pkg::GRID_ROWS)) &&
                   (col_c >= 19'sd0) && (col_c < 19'(lbev_pkg::GRID_COLS));

  lbev_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign cnt_old = ram_rdata[DW-1 -: 6];
  assign hgt_old = ram_rdata[15:8];
  assign int_old = ram_rdata[7:0];
  assign cnt_new = (cnt_old == 6'd63) ? cnt_old : cnt_old + 6'd1;
  assign hgt_new = (h_q > hgt_old) ? h_q : hgt_old;
  assign int_new = (inten_q > int_old) ? inten_q : int_old;

  lbev_ram #(
    .Width (DW),
    .Depth (lbev_pkg::CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == lbev_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lbev_pkg::ST_CLR:  if (clr_q == AW'(lbev_pkg::CELLS - 1)) state_d = lbev_pkg::ST_IDLE;
      lbev_pkg::ST_IDLE: if (in_valid_i) state_d = lbev_pkg::ST_CHK;
      lbev_pkg::ST_CHK: begin
        if (func_q == lbev_pkg::FUNC_READ) begin
          state_d = read_in_grid ? lbev_pkg::ST_RD : lbev_pkg::ST_OUT;
        end else if (is_zero || !in_roi) begin
          state_d = lbev_pkg::ST_OUT;
        end else begin
          state_d = lbev_pkg::ST_DXH;
        end
      end
      lbev_pkg::ST_DXH: if (div_done) state_d = lbev_pkg::ST_DYL;
      lbev_pkg::ST_DYL: if (div_done) state_d = lbev_pkg::ST_DX;
      lbev_pkg::ST_DX:  if (div_done) state_d = lbev_pkg::ST_DY;
      lbev_pkg::ST_DY:  if (div_done) state_d = z_open ? lbev_pkg::ST_DH : lbev_pkg::ST_GRID;
      lbev_pkg::ST_DH:  if (div_done) state_d = lbev_pkg::ST_GRID;
      lbev_pkg::ST_GRID: state_d = grid_ok ? lbev_pkg::ST_RD : lbev_pkg::ST_OUT;
      lbev_pkg::ST_RD:   state_d = lbev_pkg::ST_MOD;
      lbev_pkg::ST_MOD:  state_d = lbev_pkg::ST_OUT;
      lbev_pkg::ST_OUT:  if (out_load) state_d = lbev_pkg::ST_IDLE;
      default:           state_d = lbev_pkg::ST_CLR;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != lbev_pkg::ST_IDLE;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = '0;
    ram_raddr  = addr_q;
    case (state_q)
      lbev_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      lbev_pkg::ST_DXH, lbev_pkg::ST_DYL, lbev_pkg::ST_DX, lbev_pkg::ST_DY,
      lbev_pkg::ST_DH: begin
        div_start = !issued_q;
      end
      lbev_pkg::ST_MOD: begin
        ram_we = 1'b1;
        if (func_q != lbev_pkg::FUNC_READ) begin
          ram_wdata = {cnt_new, hgt_new, int_new};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbev_pkg::ST_CLR;
      clr_q       <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      xl_q        <= 16'sd0;
      xh_q        <= 16'sd2560;
      yl_q        <= -16'sd1280;
      yh_q        <= 16'sd1280;
      zl_q        <= -16'sd200;
      zh_q        <= 16'sd100;
      cs_q        <= 8'd10;
    end else begin
      state_q <= state_d;
      if (state_q == lbev_pkg::ST_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (div_done) begin
        issued_q <= 1'b0;
      end else if (div_start) begin
        issued_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lbev_pkg::CFG_X_LOW:     xl_q <= cfg_data_i;
          lbev_pkg::CFG_X_HIGH:    xh_q <= cfg_data_i;
          lbev_pkg::CFG_Y_LOW:     yl_q <= cfg_data_i;
          lbev_pkg::CFG_Y_HIGH:    yh_q <= cfg_data_i;
          lbev_pkg::CFG_Z_LOW:     zl_q <= cfg_data_i;
          lbev_pkg::CFG_Z_HIGH:    zh_q <= cfg_data_i;
          lbev_pkg::CFG_CELL_SIZE: cs_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lbev_pkg::ST_IDLE: begin
        func_q  <= func_i;
        x_q     <= x_coord_i;
        y_q     <= y_coord_i;
        z_q     <= z_coord_i;
        inten_q <= point_intensity_i;
        rr_q    <= read_row_i;
        rc_q    <= read_col_i;
      end
      lbev_pkg::ST_CHK: begin
        rden_q <= 8'd0;
        rhgt_q <= 8'd0;
        rint_q <= 8'd0;
        h_q    <= 8'd0;
        if (func_q == lbev_pkg::FUNC_READ) begin
          rs_q   <= lbev_pkg::STAT_READOUT;
          rrow_q <= rr_q;
          rcol_q <= rc_q;
          addr_q <= AW'(32'(rr_q) * 32'(lbev_pkg::GRID_COLS) + 32'(rc_q));
        end else begin
          rs_q   <= is_zero ? lbev_pkg::STAT_ZERO : lbev_pkg::STAT_REGION;
          rrow_q <= 8'd0;
          rcol_q <= 8'd0;
        end
      end
      lbev_pkg::ST_DXH: if (div_done) fxh_q <= floor_v;
      lbev_pkg::ST_DYL: if (div_done) fyl_q <= floor_v;
      lbev_pkg::ST_DX:  if (div_done) tx_q <= trunc_neg;
      lbev_pkg::ST_DY:  if (div_done) ty_q <= trunc_neg;
      lbev_pkg::ST_DH: begin
        if (div_done) begin
          h_q <= (div_quot > lbev_pkg::DIV_NW'(255)) ? 8'd255 : div_quot[7:0];
        end
      end
      lbev_pkg::ST_GRID: begin
        addr_q <= AW'(32'(row_c) * 32'(lbev_pkg::GRID_COLS) + 32'(col_c));
        if (grid_ok) begin
          rs_q   <= lbev_pkg::STAT_STORED;
          rrow_q <= row_c[7:0];
          rcol_q <= col_c[7:0];
        end else begin
          rs_q <= lbev_pkg::STAT_GRID;
        end
      end
      lbev_pkg::ST_MOD: begin
        if (func_q == lbev_pkg::FUNC_READ) begin
          rden_q <= lbev_pkg::DENSITY_LUT[cnt_old];
          rhgt_q <= hgt_old;
          rint_q <= int_old;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      status_o        <= rs_q;
      cell_row_o      <= rrow_q;
      cell_col_o      <= rcol_q;
      density_out_o   <= rden_q;
      height_out_o    <= rhgt_q;
      intensity_out_o <= rint_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire
